### hw/rtl/hskst_pkg.sv
// Shared types and constants for the sorted key store.
`timescale 1ns / 1ps
package hskst_pkg;

   localparam int CAPACITY = 64;
   localparam int KEY_W    = 32;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_PRINT  = 1'b1;

   typedef logic signed [KEY_W-1:0] key_type;
   typedef logic [CNT_W-1:0]        count_type;

   typedef enum logic {
      ST_IDLE,
      ST_PRINT
   } state_type;

   // Command broadcast from the sequencer to every cell of the chain.
   typedef struct packed {
      logic    insert;
      logic    rotate;
      key_type new_key;
   } chain_cmd_type;

endpackage

### hw/rtl/hskst_if.sv
// Request and response channel interfaces of the sorted key store.
`timescale 1ns / 1ps
interface hskst_req_if
   import hskst_pkg::*;
();
   logic    valid;
   logic    ready;
   logic    command;
   key_type new_key;

   modport source (output valid, output command, output new_key, input ready);
   modport sink   (input valid, input command, input new_key, output ready);
endinterface

interface hskst_rsp_if
   import hskst_pkg::*;
();
   logic    valid;
   logic    ready;
   key_type out_key;
   logic    last_of_run;
   logic    full_error;

   modport source (output valid, output out_key, output last_of_run,
                   output full_error, input ready);
   modport sink   (input valid, input out_key, input last_of_run,
                   input full_error, output ready);
endinterface

### hw/rtl/hskst_cell.sv
// One cell of the sorted chain: holds one key and its valid bit.
`timescale 1ns / 1ps
module hskst_cell
   import hskst_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  chain_cmd_type cmd,
   input  key_type       left_key,
   input  logic          left_valid,
   input  logic          left_greater,
   input  key_type       right_key,
   input  logic          right_valid,
   input  key_type       head_key,
   output key_type       key,
   output logic          valid,
   output logic          greater
);

   key_type key_ff, key_in;
   logic    valid_ff, valid_in;
   logic    take;

   assign greater = valid_ff && (key_ff > cmd.new_key);
   // A cell moves on insert if its key is larger than the new one, or if it
   // is the first empty cell.
   assign take    = greater || (!valid_ff && left_valid);

   always_comb begin
      key_in   = key_ff;
      valid_in = valid_ff;
      if (cmd.insert && take) begin
         key_in   = left_greater ? left_key : cmd.new_key;
         valid_in = 1'b1;
      end else if (cmd.rotate && valid_ff) begin
         // The last valid cell wraps around to the head's key.
         key_in = right_valid ? right_key : head_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign key   = key_ff;
   assign valid = valid_ff;

endmodule

### hw/rtl/hskst_ctrl.sv
// Request sequencer and response register of the sorted key store.
`timescale 1ns / 1ps
module hskst_ctrl
   import hskst_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   hskst_req_if.sink     req,
   hskst_rsp_if.source   rsp,
   input  key_type       head_key,
   output chain_cmd_type chain_cmd,
   output count_type     count
);

   state_type state_ff, state_in;
   count_type count_ff, count_in;
   count_type remain_ff, remain_in;
   logic      rsp_valid_ff, rsp_valid_in;
   key_type   rsp_key_ff, rsp_key_in;
   logic      rsp_last_ff, rsp_last_in;
   logic      rsp_err_ff, rsp_err_in;

   logic slot_free, accept, full, ins_ok, ins_err, print_go, step;

   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign full      = (count_ff == count_type'(CAPACITY));

   // Output decode.
   always_comb begin
      req.ready = (state_ff == ST_IDLE) && slot_free;
      accept    = req.valid && req.ready;
      ins_ok    = accept && (req.command == CMD_INSERT) && !full;
      ins_err   = accept && (req.command == CMD_INSERT) && full;
      print_go  = accept && (req.command == CMD_PRINT) && (count_ff != '0);
      step      = (state_ff == ST_PRINT) && slot_free;
      chain_cmd.insert  = ins_ok;
      chain_cmd.rotate  = step;
      chain_cmd.new_key = req.new_key;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (print_go) state_in = ST_PRINT;
         end
         ST_PRINT: begin
            if (step && (remain_ff == count_type'(1))) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      count_in     = ins_ok ? count_ff + count_type'(1) : count_ff;
      remain_in    = remain_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_err_in   = rsp_err_ff;
      if (print_go) begin
         remain_in = count_ff;
      end else if (step) begin
         remain_in = remain_ff - count_type'(1);
      end
      if (step) begin
         rsp_valid_in = 1'b1;
         rsp_key_in   = head_key;
         rsp_last_in  = (remain_ff == count_type'(1));
         rsp_err_in   = 1'b0;
      end else if (ins_err) begin
         rsp_valid_in = 1'b1;
         rsp_key_in   = '0;
         rsp_last_in  = 1'b1;
         rsp_err_in   = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      remain_ff   <= remain_in;
      rsp_key_ff  <= rsp_key_in;
      rsp_last_ff <= rsp_last_in;
      rsp_err_ff  <= rsp_err_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.out_key     = rsp_key_ff;
   assign rsp.last_of_run = rsp_last_ff;
   assign rsp.full_error  = rsp_err_ff;
   assign count           = count_ff;

endmodule

### hw/rtl/heap_sorted_key_store.sv
// Top level of the sorted key store: the cell chain and its sequencer.
`timescale 1ns / 1ps
// Keeps up to CAPACITY signed 32-bit keys in ascending order in a chain of
// cells, one key per cell. On an insert request the key is broadcast along
// the chain, every larger key moves one cell up, and the new key drops into
// the gap, so inserts are accepted one per cycle. No request is accepted
// while a response waits in the output register and rsp is not ready. An
// insert into a full store is dropped and gives one response with full_error
// and last_of_run set. A print request streams the n stored keys smallest
// first, one per cycle while rsp is ready, by rotating the chain toward cell
// zero n times; the store accepts no request meanwhile. Printing an empty
// store gives no response.
module heap_sorted_key_store
   import hskst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   hskst_req_if.sink   req,
   hskst_rsp_if.source rsp
);

   chain_cmd_type         chain_cmd;
   count_type             count;
   key_type               cell_key [CAPACITY];
   logic [CAPACITY-1:0]   cell_valid;
   logic [CAPACITY-1:0]   cell_greater;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      key_type left_key, right_key;
      logic    left_valid, left_greater, right_valid;

      if (i == 0) begin : g_first
         assign left_key     = '0;
         assign left_valid   = 1'b1;
         assign left_greater = 1'b0;
      end else begin : g_mid
         assign left_key     = cell_key[i-1];
         assign left_valid   = cell_valid[i-1];
         assign left_greater = cell_greater[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_key   = '0;
         assign right_valid = 1'b0;
      end else begin : g_inner
         assign right_key   = cell_key[i+1];
         assign right_valid = cell_valid[i+1];
      end

      hskst_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .cmd          (chain_cmd),
         .left_key     (left_key),
         .left_valid   (left_valid),
         .left_greater (left_greater),
         .right_key    (right_key),
         .right_valid  (right_valid),
         .head_key     (cell_key[0]),
         .key          (cell_key[i]),
         .valid        (cell_valid[i]),
         .greater      (cell_greater[i])
      );
   end

   hskst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .head_key  (cell_key[0]),
      .chain_cmd (chain_cmd),
      .count     (count)
   );

   // The number of valid cells always equals the entry count.
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == int'(count))
      else $error("valid cells do not match entry count");

   // An error response carries a zero key and closes its run.
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.full_error |-> rsp.last_of_run && (rsp.out_key == '0))
      else $error("malformed full error response");

   // While a request can be accepted, the first two cells are in ascending order.
   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      req.ready && cell_valid[1] |-> cell_key[0] <= cell_key[1])
      else $error("chain head out of order");

   // A full store never grows further.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count == count_type'(CAPACITY) |=> count == count_type'(CAPACITY))
      else $error("entry count passed capacity");

endmodule
